// File: rtl/timed_release_queue_with_ttl_core_macros.svh
// Assertion macros used by the queue controller.
`ifndef TIMED_RELEASE_QUEUE_WITH_TTL_CORE_MACROS_SVH
`define TIMED_RELEASE_QUEUE_WITH_TTL_CORE_MACROS_SVH
// implication checked every clock outside reset
`define TRQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TRQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/trq_pkg.sv
// Package: payload structs, state enum and command codes for the release queue.
`default_nettype none
package trq_pkg;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] KIND_DELIVERED = 2'd0;
  localparam logic [1:0] KIND_DROPPED   = 2'd1;
  localparam logic [1:0] KIND_FULL      = 2'd2;
  localparam logic [1:0] KIND_NONE      = 2'd3;

  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_TTL   = 1'b1;

  localparam logic [47:0] TTL_RESET = 48'd5000000;

  // most packets released by one tick
  localparam int MAX_OUT = 16;

  typedef struct packed {
    logic        command;
    logic [47:0] in_rx_time;
    logic [15:0] in_dst_id;
    logic [15:0] in_src_id;
    logic [15:0] in_flow_id;
    logic [31:0] in_seq;
    logic [15:0] in_payload_tag;
    logic        payload_empty;
    logic [47:0] step_end_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_payload_tag;
    logic [15:0] out_dst_id;
    logic [15:0] out_src_id;
    logic [15:0] out_flow_id;
    logic [31:0] out_seq;
    logic [47:0] out_due_time;
    logic        last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INSERT, ST_SHIFT, ST_TICK, ST_EMIT, ST_POP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input request
    logic calc;      // compute due time / compare vector
    logic ins;       // shift and write the new entry
    logic pop;       // remove head entry
    logic emit;      // load output register
    logic emit_kind; // 0 packet, 1 status-only
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic drop_in;
    logic full;
    logic head_due;   // head valid and due, tick release limit not reached
    logic last_pkt;   // no further due packet after head within the tick limit
    logic any_out;    // at least one released this tick
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/timed_release_queue_with_ttl_core.sv
// Top level of the timed release queue with TTL drop.
// A sorted queue of QUEUE_DEPTH packets in registers. An insert steps through capture,
// compare against every entry in parallel lanes and shift-in, and gives no result unless
// the queue is full; a rejected or ignored insert skips the shift-in. A tick ends with a
// status request when nothing is due, otherwise emits and pops each released packet in
// turn; at most 16 packets leave per tick. The single output register sets the pace: a
// stalled result holds the controller until it is taken.
`default_nettype none
module timed_release_queue_with_ttl_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trq_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trq_pkg::out_req_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [47:0]       cfg_data
);
  trq_pkg::cmd_t  cmd;
  trq_pkg::stat_t st;
  logic in_fire;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  trq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_rdy(in_ready), .st(st), .cmd(cmd)
  );

  trq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_req(in_data),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .st(st), .out_req(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule
`default_nettype wire

// File: rtl/trq_ctrl.sv
// Controller state machine sequencing inserts and tick releases.
`default_nettype none
`include "timed_release_queue_with_ttl_core_macros.svh"
module trq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  output logic              in_rdy,
  input  wire trq_pkg::stat_t st,
  output trq_pkg::cmd_t     cmd
);
  trq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= trq_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      trq_pkg::ST_IDLE:   if (in_fire) state_next = trq_pkg::ST_INSERT;
      trq_pkg::ST_INSERT: begin
        if (st.is_tick) state_next = trq_pkg::ST_TICK;
        else if (st.drop_in) state_next = trq_pkg::ST_IDLE;
        else if (st.full) state_next = st.out_busy ? trq_pkg::ST_INSERT : trq_pkg::ST_IDLE;
        else state_next = trq_pkg::ST_SHIFT;
      end
      trq_pkg::ST_SHIFT:  state_next = trq_pkg::ST_IDLE;
      trq_pkg::ST_TICK: begin
        if (!st.out_busy) begin
          if (st.head_due) state_next = trq_pkg::ST_POP;
          else state_next = trq_pkg::ST_IDLE;
        end
      end
      trq_pkg::ST_POP:    state_next = st.last_pkt ? trq_pkg::ST_IDLE : trq_pkg::ST_TICK;
      trq_pkg::ST_EMIT:   state_next = trq_pkg::ST_IDLE;
      default:            state_next = trq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_rdy = 1'b0;
    unique case (state)
      trq_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        cmd.load = in_fire;
      end
      trq_pkg::ST_INSERT: begin
        cmd.calc = 1'b1;
        if (!st.is_tick && !st.drop_in && st.full && !st.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = 1'b1;
        end
      end
      trq_pkg::ST_SHIFT: cmd.ins = 1'b1;
      trq_pkg::ST_TICK: begin
        if (!st.out_busy) begin
          cmd.emit = st.head_due || !st.any_out;
          cmd.emit_kind = !st.head_due;
        end
      end
      trq_pkg::ST_POP: cmd.pop = 1'b1;
      trq_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  `TRQ_ASSERT_NXT(a_shift_once, clk, rst, state == trq_pkg::ST_SHIFT,
    state == trq_pkg::ST_IDLE, "insert shift lasted more than one cycle")
  `TRQ_ASSERT_IMP(a_pop_after_emit, clk, rst, cmd.pop,
    $past(cmd.emit), "pop without emitted result")
  `TRQ_ASSERT_IMP(a_no_emit_busy, clk, rst, cmd.emit, !st.out_busy,
    "result emitted over pending result")
endmodule
`default_nettype wire

// File: rtl/trq_datapath.sv
// Datapath: sorted entry registers, due-time adder, compare and output register.
`default_nettype none
module trq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire trq_pkg::in_req_t in_req,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [47:0]      cfg_data,
  input  wire trq_pkg::cmd_t    cmd,
  output trq_pkg::stat_t        st,
  output trq_pkg::out_req_t     out_req,
  output logic                  out_valid,
  input  wire logic             out_ready
);
  localparam int RW = $clog2(trq_pkg::MAX_OUT + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [47:0] delay, ttl;
  trq_pkg::in_req_t rq;
  logic [TIME_BITS-1:0] now_t, rx_t, due_t;
  logic [QUEUE_DEPTH-1:0] vld, goes_first;
  logic [RW-1:0] released;

  logic [TIME_BITS-1:0] q_due [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] q_rx  [QUEUE_DEPTH];
  logic [15:0] q_dst [QUEUE_DEPTH];
  logic [15:0] q_src [QUEUE_DEPTH];
  logic [15:0] q_flow[QUEUE_DEPTH];
  logic [31:0] q_seq [QUEUE_DEPTH];
  logic [15:0] q_tag [QUEUE_DEPTH];

  logic [TIME_BITS:0] sum;
  logic [TIME_BITS-1:0] dly_t;
  logic [TIME_BITS-1:0] age;
  logic expired;

  assign dly_t = TIME_BITS'(delay);
  assign rx_t  = TIME_BITS'(rq.in_rx_time);
  assign now_t = TIME_BITS'(rq.step_end_time);
  assign sum   = {1'b0, rx_t} + {1'b0, dly_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= '0;
      ttl <= trq_pkg::TTL_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == trq_pkg::REG_DELAY) delay <= cfg_data;
      else ttl <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rq <= in_req;
    if (cmd.calc) due_t <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
  end

  // key compare against each entry: one wide compare per lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.ins == 1'b0)
        goes_first[i] <= {(sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0]), rx_t, rq.in_dst_id,
                          rq.in_src_id, rq.in_flow_id, rq.in_seq}
                       < {q_due[i], q_rx[i], q_dst[i], q_src[i], q_flow[i], q_seq[i]};
    end
  end

  // valid entries sorting after the new packet move up one slot; the new packet
  // lands in the first slot that is empty or sorts after it
  logic [QUEUE_DEPTH-1:0] take_new, shift_in, moved, kept;
  always_comb begin
    moved    = vld & goes_first;
    kept     = vld & ~goes_first;
    shift_in = {moved[QUEUE_DEPTH-2:0], 1'b0};
    take_new = (~vld | goes_first) & {kept[QUEUE_DEPTH-2:0], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (cmd.ins) begin
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (take_new[i] || shift_in[i]) vld[i] <= 1'b1;
    end else if (cmd.pop) begin
      vld <= vld >> 1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.ins && take_new[i]) begin
        q_due[i] <= due_t; q_rx[i] <= rx_t; q_dst[i] <= rq.in_dst_id;
        q_src[i] <= rq.in_src_id; q_flow[i] <= rq.in_flow_id;
        q_seq[i] <= rq.in_seq; q_tag[i] <= rq.in_payload_tag;
      end else if (cmd.ins && shift_in[i]) begin
        q_due[i] <= q_due[(i > 0) ? i-1 : 0]; q_rx[i] <= q_rx[(i > 0) ? i-1 : 0];
        q_dst[i] <= q_dst[(i > 0) ? i-1 : 0]; q_src[i] <= q_src[(i > 0) ? i-1 : 0];
        q_flow[i] <= q_flow[(i > 0) ? i-1 : 0];
        q_seq[i] <= q_seq[(i > 0) ? i-1 : 0]; q_tag[i] <= q_tag[(i > 0) ? i-1 : 0];
      end else if (cmd.pop) begin
        q_due[i] <= q_due[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_rx[i] <= q_rx[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_dst[i] <= q_dst[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_src[i] <= q_src[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_flow[i] <= q_flow[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_seq[i] <= q_seq[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_tag[i] <= q_tag[(i < QUEUE_DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) released <= '0;
    else if (cmd.pop) released <= released + 1'b1;
  end

  logic head_ok, next_ok;
  assign head_ok = vld[0] && (q_due[0] <= now_t) && (released < RW'(trq_pkg::MAX_OUT));
  assign next_ok = vld[1] && (q_due[1] <= now_t) &&
                   (RW'(released + 1'b1) < RW'(trq_pkg::MAX_OUT));
  assign age = now_t - q_rx[0];
  assign expired = (ttl != '0) && (now_t > q_rx[0]) && (64'(age) > 64'(ttl));

  always_comb begin
    st.is_tick  = rq.command == trq_pkg::CMD_TICK;
    st.drop_in  = rq.payload_empty;
    st.full     = vld[QUEUE_DEPTH-1];
    st.head_due = head_ok;
    st.last_pkt = !next_ok;
    st.any_out  = released != '0;
    st.out_busy = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  trq_pkg::out_req_t emit_req;
  always_comb begin
    emit_req = '0;
    emit_req.last = 1'b1;
    if (cmd.emit_kind) begin
      emit_req.kind = st.is_tick ? trq_pkg::KIND_NONE : trq_pkg::KIND_FULL;
    end else begin
      emit_req.kind = expired ? trq_pkg::KIND_DROPPED : trq_pkg::KIND_DELIVERED;
      emit_req.out_payload_tag = q_tag[0];
      emit_req.out_dst_id = q_dst[0];
      emit_req.out_src_id = q_src[0];
      emit_req.out_flow_id = q_flow[0];
      emit_req.out_seq = q_seq[0];
      emit_req.out_due_time = 48'(q_due[0]);
      emit_req.last = !next_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_req <= emit_req;
  end
endmodule
`default_nettype wire
